FILE: sv/script_lexer_tokenizer_core_defines.svh
// Assertion macros shared by the lexer core modules.
// Included by every module that carries concurrent checks; needs nothing else.
`ifndef SCRIPT_LEXER_TOKENIZER_CORE_DEFINES_SVH
`define SCRIPT_LEXER_TOKENIZER_CORE_DEFINES_SVH

`ifndef SYNTH
// The expression must hold at every clock edge outside reset.
`define SLT_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("check failed: always");
// When the first expression holds, the second must hold in the same cycle.
`define SLT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: implication");
// When the first expression holds, the second must hold in the next cycle.
`define SLT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next cycle");
`else
`define SLT_ASSERT_ALWAYS(name, clk, rst, expr)
`define SLT_ASSERT_IMPL(name, clk, rst, ante, cons)
`define SLT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: sv/slt_pkg.sv
// Shared types and constants of the script lexer core.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package slt_pkg;

   // Default widths and sizes.
   localparam int LINE_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int LINE_OUT_W          = 32;
   localparam int MAX_RES             = 3;
   localparam int CNT_W               = 2;

   // Token kinds.
   typedef enum logic [3:0] {
      KIND_EOS    = 4'd0,
      KIND_NUM    = 4'd1,
      KIND_STR    = 4'd2,
      KIND_ID     = 4'd3,
      KIND_VAR    = 4'd4,
      KIND_FUNC   = 4'd5,
      KIND_LCOM   = 4'd6,
      KIND_BCOM   = 4'd7,
      KIND_CHAR   = 4'd8
   } kind_type;

   // Error codes.
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_NUM   = 3'd1,
      ERR_BAD_ESC   = 3'd2,
      ERR_UNTERM_STR = 3'd3,
      ERR_UNTERM_COM = 3'd4
   } error_type;

   // One result item without its line number.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       token_end;
      kind_type   kind;
      error_type  err;
   } res_type;

   // All results caused by one input item, as held in the queue.
   typedef struct packed {
      logic [CNT_W-1:0]            cnt;
      logic [LINE_OUT_W-1:0]       line;
      res_type [MAX_RES-1:0]       res;
   } group_type;

endpackage

FILE: sv/slt_front.sv
// Lexer front end: accepts source bytes, runs the lexing state machine and
// builds the result group of each byte. Depends on slt_pkg and the defines header.
`timescale 1ns / 1ps
`include "script_lexer_tokenizer_core_defines.svh"

module slt_front #(
   parameter int LINE_BITS = slt_pkg::LINE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_in_byte,
   input  logic               req_end_of_input,
   input  logic               q_full,
   output logic               push,
   output slt_pkg::group_type push_group
);

   typedef enum logic [12:0] {
      M_IDLE    = 13'b0000000000001,
      M_SLASH   = 13'b0000000000010,
      M_INT     = 13'b0000000000100,
      M_DOT     = 13'b0000000001000,
      M_FRAC    = 13'b0000000010000,
      M_EXPMARK = 13'b0000000100000,
      M_EXPSIGN = 13'b0000001000000,
      M_EXP     = 13'b0000010000000,
      M_STR     = 13'b0000100000000,
      M_ESC     = 13'b0001000000000,
      M_IDENT   = 13'b0010000000000,
      M_LCOM    = 13'b0100000000000,
      M_BCOM    = 13'b1000000000000
   } mode_type;

   // Newline partner expectation codes.
   localparam logic [1:0] NL_NONE    = 2'd0;
   localparam logic [1:0] NL_WANT_LF = 2'd1;
   localparam logic [1:0] NL_WANT_CR = 2'd2;

   // Keyword tracker codes: v, va, var, f, fu, fun, func.
   localparam logic [2:0] KW_NONE = 3'd0;
   localparam logic [2:0] KW_V    = 3'd1;
   localparam logic [2:0] KW_VA   = 3'd2;
   localparam logic [2:0] KW_VAR  = 3'd3;
   localparam logic [2:0] KW_F    = 3'd4;
   localparam logic [2:0] KW_FU   = 3'd5;
   localparam logic [2:0] KW_FUN  = 3'd6;
   localparam logic [2:0] KW_FUNC = 3'd7;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_UND   = 8'h5F;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == CH_UND);
   endfunction

   function automatic logic is_nl(input logic [7:0] c);
      return (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic [1:0] nl_code(input logic [7:0] c);
      return (c == CH_LF) ? NL_WANT_CR : NL_WANT_LF;
   endfunction

   function automatic logic [2:0] kw_next(input logic [2:0] k, input logic [7:0] c);
      logic [2:0] r;
      r = KW_NONE;
      case (k)
         KW_V:    r = (c == "a") ? KW_VA   : KW_NONE;
         KW_VA:   r = (c == "r") ? KW_VAR  : KW_NONE;
         KW_F:    r = (c == "u") ? KW_FU   : KW_NONE;
         KW_FU:   r = (c == "n") ? KW_FUN  : KW_NONE;
         KW_FUN:  r = (c == "c") ? KW_FUNC : KW_NONE;
         default: r = KW_NONE;
      endcase
      return r;
   endfunction

   function automatic slt_pkg::res_type mk_res(input logic [7:0] c, input logic bv,
                                                input logic te,
                                                input slt_pkg::kind_type k,
                                                input slt_pkg::error_type e);
      slt_pkg::res_type r;
      r.out_byte   = c;
      r.byte_valid = bv;
      r.token_end  = te;
      r.kind       = k;
      r.err        = e;
      return r;
   endfunction

   mode_type                 mode_ff, mode_in;
   logic [2:0]               kw_ff, kw_in;
   logic [1:0]               nl_ff, nl_in;
   logic [LINE_BITS-1:0]     line_ff, line_in, line_inc;
   logic                     star_ff, star_in;

   logic [7:0]               b;
   logic                     eoi;
   logic                     accept;
   logic                     drop;
   logic                     no_count;
   logic                     go_idle;
   logic                     inc;
   logic                     post_line;
   logic [1:0]               n;
   slt_pkg::res_type [slt_pkg::MAX_RES-1:0] res_c;
   logic [7:0]               esc_c;
   logic                     esc_known;

   assign b        = req_in_byte;
   assign eoi      = req_end_of_input;
   assign accept   = req_valid && !q_full;
   assign line_inc = line_ff + LINE_BITS'(1);

   // Escape decoding for the byte after a backslash.
   always_comb begin
      esc_known = 1'b1;
      esc_c     = b;
      case (b)
         "a":     esc_c = 8'h07;
         "b":     esc_c = 8'h08;
         "f":     esc_c = CH_FF;
         "n":     esc_c = CH_LF;
         "r":     esc_c = CH_CR;
         "t":     esc_c = CH_TAB;
         "v":     esc_c = CH_VT;
         CH_BSL, CH_QUOTE, CH_APOS: esc_c = b;
         default: esc_known = 1'b0;
      endcase
   end

   // One lexing step: next state and the results of the current byte.
   always_comb begin
      mode_in   = mode_ff;
      kw_in     = kw_ff;
      nl_in     = nl_ff;
      star_in   = star_ff;
      drop      = 1'b0;
      no_count  = 1'b0;
      go_idle   = 1'b0;
      inc       = 1'b0;
      post_line = 1'b0;
      n         = 2'd0;
      res_c     = '0;

      // Second byte of a CR/LF or LF/CR pair.
      if (nl_ff != NL_NONE) begin
         nl_in = NL_NONE;
         if (!eoi && (b == ((nl_ff == NL_WANT_LF) ? CH_LF : CH_CR))) begin
            if (mode_ff != M_BCOM) begin
               drop = 1'b1;
            end else begin
               no_count = 1'b1;
            end
         end
      end

      if (!drop) begin
         unique case (mode_ff)
            M_SLASH: begin
               mode_in = M_IDLE;
               if (!eoi && (b == CH_SLASH)) begin
                  mode_in = M_LCOM;
               end else if (!eoi && (b == CH_STAR)) begin
                  mode_in = M_BCOM;
                  star_in = 1'b0;
               end else begin
                  res_c[n] = mk_res(CH_SLASH, 1'b1, 1'b1, slt_pkg::KIND_CHAR,
                                    slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_INT, M_FRAC: begin
               if (!eoi && is_digit(b)) begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end else if (!eoi && (b == CH_DOT) && (mode_ff == M_INT)) begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_DOT;
               end else if (!eoi && ((b == "e") || (b == "E"))) begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_EXPMARK;
               end else begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_NUM, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_DOT, M_EXPSIGN: begin
               if (!eoi && is_digit(b)) begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  mode_in = (mode_ff == M_DOT) ? M_FRAC : M_EXP;
               end else begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_NUM,
                                    slt_pkg::ERR_BAD_NUM);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_EXPMARK: begin
               if (!eoi && is_digit(b)) begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_EXP;
               end else if (!eoi && ((b == CH_PLUS) || (b == CH_MINUS))) begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_EXPSIGN;
               end else begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_NUM,
                                    slt_pkg::ERR_BAD_NUM);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_EXP: begin
               if (!eoi && is_digit(b)) begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_NUM, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_STR: begin
               if (eoi || is_nl(b)) begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_STR,
                                    slt_pkg::ERR_UNTERM_STR);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end else if (b == CH_QUOTE) begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_STR, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_IDLE;
               end else if (b == CH_BSL) begin
                  mode_in = M_ESC;
               end else begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end
            end
            M_ESC: begin
               if (eoi) begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_STR,
                                    slt_pkg::ERR_UNTERM_STR);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end else if (is_nl(b)) begin
                  // An escaped line break is kept as LF and counts a line.
                  mode_in   = M_STR;
                  inc       = 1'b1;
                  post_line = 1'b1;
                  nl_in     = nl_code(b);
                  res_c[n]  = mk_res(CH_LF, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end else if (esc_known) begin
                  mode_in  = M_STR;
                  res_c[n] = mk_res(esc_c, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  mode_in  = M_IDLE;
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_STR,
                                    slt_pkg::ERR_BAD_ESC);
                  n = n + 2'd1;
               end
            end
            M_IDENT: begin
               if (!eoi && (is_alpha(b) || is_digit(b))) begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  kw_in = kw_next(kw_ff, b);
               end else begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1,
                                    (kw_ff == KW_VAR)  ? slt_pkg::KIND_VAR :
                                    (kw_ff == KW_FUNC) ? slt_pkg::KIND_FUNC :
                                                         slt_pkg::KIND_ID,
                                    slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  kw_in   = KW_NONE;
                  go_idle = 1'b1;
               end
            end
            M_LCOM: begin
               if (eoi) begin
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_LCOM, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end else if (is_nl(b)) begin
                  inc       = 1'b1;
                  post_line = 1'b1;
                  nl_in     = nl_code(b);
                  mode_in   = M_IDLE;
                  res_c[n]  = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_LCOM,
                                     slt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end
            end
            M_BCOM: begin
               if (eoi) begin
                  star_in  = 1'b0;
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_BCOM,
                                    slt_pkg::ERR_UNTERM_COM);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end else if (star_ff && (b == CH_SLASH)) begin
                  star_in  = 1'b0;
                  mode_in  = M_IDLE;
                  res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_BCOM, slt_pkg::ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  // A held star that did not close the comment is text.
                  if (star_ff) begin
                     res_c[n] = mk_res(CH_STAR, 1'b1, 1'b0, slt_pkg::KIND_EOS,
                                       slt_pkg::ERR_NONE);
                     n = n + 2'd1;
                     star_in = 1'b0;
                  end
                  if (b == CH_STAR) begin
                     star_in = 1'b1;
                  end else begin
                     res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
                     n = n + 2'd1;
                     if (is_nl(b) && !no_count) begin
                        inc   = 1'b1;
                        nl_in = nl_code(b);
                     end
                  end
               end
            end
            default: begin
               go_idle = 1'b1;
            end
         endcase
      end

      // Byte handled from idle, either directly or after a token closed.
      if (go_idle) begin
         mode_in = M_IDLE;
         if (eoi) begin
            res_c[n] = mk_res(8'h00, 1'b0, 1'b1, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
            n = n + 2'd1;
         end else if (is_nl(b)) begin
            inc   = 1'b1;
            nl_in = nl_code(b);
         end else if ((b == CH_SP) || (b == CH_FF) || (b == CH_TAB) || (b == CH_VT)) begin
            mode_in = M_IDLE;
         end else if (b == CH_SLASH) begin
            mode_in = M_SLASH;
         end else if (b == CH_QUOTE) begin
            mode_in = M_STR;
         end else if (is_digit(b)) begin
            mode_in  = M_INT;
            res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
            n = n + 2'd1;
         end else if (is_alpha(b)) begin
            mode_in  = M_IDENT;
            kw_in    = (b == "v") ? KW_V : (b == "f") ? KW_F : KW_NONE;
            res_c[n] = mk_res(b, 1'b1, 1'b0, slt_pkg::KIND_EOS, slt_pkg::ERR_NONE);
            n = n + 2'd1;
         end else begin
            res_c[n] = mk_res(b, 1'b1, 1'b1, slt_pkg::KIND_CHAR, slt_pkg::ERR_NONE);
            n = n + 2'd1;
         end
      end

      line_in = inc ? line_inc : line_ff;
   end

   // Group handed to the queue; bytes that cause no result push nothing.
   always_comb begin
      push_group.cnt  = n;
      push_group.line = post_line ? slt_pkg::LINE_OUT_W'(line_inc)
                                  : slt_pkg::LINE_OUT_W'(line_ff);
      push_group.res  = res_c;
      push            = accept && (n != 2'd0);
   end

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         kw_ff   <= KW_NONE;
         nl_ff   <= NL_NONE;
         line_ff <= LINE_BITS'(1);
         star_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         kw_ff   <= kw_in;
         nl_ff   <= nl_in;
         line_ff <= line_in;
         star_ff <= star_in;
      end
   end

   `SLT_ASSERT_IMPL(a_push_not_full, clock, reset, push, !q_full)
   `SLT_ASSERT_IMPL(a_star_only_in_bcom, clock, reset, star_ff, mode_ff == M_BCOM)

endmodule

FILE: sv/slt_queue.sv
// Short register queue of result groups between the lexer front and back end.
// Depends on slt_pkg and the defines header.
`timescale 1ns / 1ps
`include "script_lexer_tokenizer_core_defines.svh"

module slt_queue #(
   parameter int DEPTH = slt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  slt_pkg::group_type push_group,
   output logic               full,
   input  logic               pop,
   output slt_pkg::group_type head_group,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   slt_pkg::group_type   store_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign head_group = store_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Group storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_group;
      end
   end

   `SLT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `SLT_ASSERT_IMPL(a_pop_not_empty, clock, reset, pop, !empty)

endmodule

FILE: sv/slt_back.sv
// Lexer back end: takes result groups from the queue and hands out one result item per cycle
// while not stalled and marks the last of each group. Needs slt_pkg and the defines header.
`timescale 1ns / 1ps
`include "script_lexer_tokenizer_core_defines.svh"

module slt_back (
   input  logic               clock,
   input  logic               reset,
   input  slt_pkg::group_type head_group,
   input  logic               q_empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_token_end,
   output logic [3:0]         rsp_token_kind,
   output logic [2:0]         rsp_error_code,
   output logic [31:0]        rsp_line_number,
   output logic               rsp_last_result
);

   slt_pkg::group_type cur_ff, cur_in;
   logic               valid_ff, valid_in;
   logic [1:0]         idx_ff, idx_in;
   logic               last;
   logic               out_acc;
   slt_pkg::res_type   res_sel;

   assign last    = (idx_ff == (cur_ff.cnt - 2'd1));
   assign out_acc = valid_ff && !rsp_stall;
   assign pop     = !q_empty && (!valid_ff || (out_acc && last));
   assign res_sel = cur_ff.res[idx_ff];

   // Step through the current group; load the next one as the last item leaves.
   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         cur_in   = head_group;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (out_acc) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Result ports.
   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = res_sel.out_byte;
   assign rsp_byte_valid  = res_sel.byte_valid;
   assign rsp_token_end   = res_sel.token_end;
   assign rsp_token_kind  = res_sel.kind;
   assign rsp_error_code  = res_sel.err;
   assign rsp_line_number = cur_ff.line;
   assign rsp_last_result = last;

   `SLT_ASSERT_IMPL(a_idx_in_group, clock, reset, valid_ff,
                    (cur_ff.cnt != 2'd0) && (idx_ff < cur_ff.cnt))
   `SLT_ASSERT_NEXT(a_stall_holds_item, clock, reset, valid_ff && rsp_stall,
                    valid_ff && (idx_ff == $past(idx_ff)))

endmodule

FILE: sv/script_lexer_tokenizer_core.sv
// Script lexer core: one source byte per cycle in, token results out one per cycle.
// Each byte's results are registered in the group queue, then in the output stage.
// Throughput: one byte per cycle while the group queue has room; a byte makes
// zero to two results, and the output gives one result per cycle unless rsp_stall.
// Reset (synchronous): lexer idle, line count one, queue and output empty.
`timescale 1ns / 1ps

module script_lexer_tokenizer_core #(
   parameter int LINE_BITS   = slt_pkg::LINE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = slt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_token_end,
   output logic [3:0]  rsp_token_kind,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_line_number,
   output logic        rsp_last_result
);

   logic               push;
   slt_pkg::group_type push_group;
   logic               q_full;
   logic               q_empty;
   logic               pop;
   slt_pkg::group_type head_group;

   // Input is held off only while the queue is full.
   assign req_stall = q_full;

   slt_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .push             (push),
      .push_group       (push_group)
   );

   slt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (q_full),
      .pop        (pop),
      .head_group (head_group),
      .empty      (q_empty)
   );

   slt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_group      (head_group),
      .q_empty         (q_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_token_end   (rsp_token_end),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_error_code  (rsp_error_code),
      .rsp_line_number (rsp_line_number),
      .rsp_last_result (rsp_last_result)
   );

endmodule
